/* src/owtr_pkg.sv */
// shared types, constants and sequencing functions for the single-wire temperature master
package owtr_pkg;

	localparam int TIMER_BITS_DEF = 20;
	localparam int CFG_DATA_W     = 20;
	localparam int CFG_INDEX_W    = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRES_DELAY    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRES_TIMEOUT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_RECOVER = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WRITE_SLOT    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_SLOT     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CONV_WAIT     = 3'd6;

	// operation codes
	localparam logic [1:0] OP_RESET = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_TEMP  = 2'd3;

	// bus commands
	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

	// index of the high-byte read in the temperature sequence
	localparam logic [3:0] STEP_HIGH_BYTE = 4'd8;
	localparam int         TEMP_LEN       = 10;

	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_RLOW = 8'b0000_0010,
		PH_RDLY = 8'b0000_0100,
		PH_PRES = 8'b0000_1000,
		PH_RREC = 8'b0001_0000,
		PH_WBIT = 8'b0010_0000,
		PH_RBIT = 8'b0100_0000,
		PH_CONV = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		IT_END   = 3'd0,
		IT_RESET = 3'd1,
		IT_WCC   = 3'd2,
		IT_W44   = 3'd3,
		IT_CONV  = 3'd4,
		IT_WBE   = 3'd5,
		IT_READ  = 3'd6,
		IT_WUSER = 3'd7
	} item_code_t;

	localparam item_code_t TEMP_ITEMS [0:TEMP_LEN-1] = '{
		IT_RESET, IT_WCC, IT_W44, IT_CONV, IT_RESET, IT_WCC, IT_WBE, IT_READ, IT_READ, IT_END
	};

	typedef struct packed {
		logic [11:0] reset_low;
		logic [9:0]  pres_delay;
		logic [9:0]  pres_timeout;
		logic [9:0]  reset_recover;
		logic [9:0]  write_slot;
		logic [9:0]  read_slot;
		logic [19:0] conv_wait;
	} cfg_t;

	typedef struct packed {
		logic       start_req;
		logic [1:0] operation;
		logic [7:0] write_byte;
		logic       line_level;
	} tick_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic        presence_ok;
		logic [15:0] read_value;
	} res_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] shift;
		logic [3:0] step;
		logic       fin;
	} begin_t;

	function automatic item_code_t item_of(input logic [1:0] op, input logic [3:0] step);
		item_code_t it;
		it = IT_END;
		case (op)
			OP_RESET: it = (step == 4'd0) ? IT_RESET : IT_END;
			OP_WRITE: it = (step == 4'd0) ? IT_WUSER : IT_END;
			OP_READ:  it = (step == 4'd0) ? IT_READ : IT_END;
			OP_TEMP:  it = (step < 4'(TEMP_LEN)) ? TEMP_ITEMS[step] : IT_END;
			default:  it = IT_END;
		endcase
		return it;
	endfunction

	// set up a sequence step; a zero conversion wait is skipped over
	function automatic begin_t begin_step(input logic [1:0] op, input logic [3:0] step,
		input logic [7:0] user_byte, input logic conv_zero);
		item_code_t it;
		logic [3:0] st;
		begin_t     r;
		st = step;
		it = item_of(op, st);
		if (it == IT_CONV && conv_zero) begin
			st = st + 4'd1;
			it = item_of(op, st);
		end
		r.step  = st;
		r.shift = 8'h00;
		r.fin   = 1'b0;
		r.phase = PH_IDLE;
		case (it)
			IT_RESET: r.phase = PH_RLOW;
			IT_WCC: begin
				r.phase = PH_WBIT;
				r.shift = CMD_SKIP_ROM;
			end
			IT_W44: begin
				r.phase = PH_WBIT;
				r.shift = CMD_CONVERT;
			end
			IT_WBE: begin
				r.phase = PH_WBIT;
				r.shift = CMD_READ_PAD;
			end
			IT_WUSER: begin
				r.phase = PH_WBIT;
				r.shift = user_byte;
			end
			IT_READ:  r.phase = PH_RBIT;
			IT_CONV:  r.phase = PH_CONV;
			default:  r.fin = 1'b1;
		endcase
		return r;
	endfunction

endpackage

/* src/owtr_cfg.sv */
// timing configuration registers of the single-wire master
module owtr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [owtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [owtr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output owtr_pkg::cfg_t                    cfg
);

	owtr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= 12'd500;
			cfg_q.pres_delay    <= 10'd30;
			cfg_q.pres_timeout  <= 10'd254;
			cfg_q.reset_recover <= 10'd120;
			cfg_q.write_slot    <= 10'd40;
			cfg_q.read_slot     <= 10'd80;
			cfg_q.conv_wait     <= 20'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				owtr_pkg::REG_RESET_LOW:     cfg_q.reset_low     <= cfg_data[11:0];
				owtr_pkg::REG_PRES_DELAY:    cfg_q.pres_delay    <= cfg_data[9:0];
				owtr_pkg::REG_PRES_TIMEOUT:  cfg_q.pres_timeout  <= cfg_data[9:0];
				owtr_pkg::REG_RESET_RECOVER: cfg_q.reset_recover <= cfg_data[9:0];
				owtr_pkg::REG_WRITE_SLOT:    cfg_q.write_slot    <= cfg_data[9:0];
				owtr_pkg::REG_READ_SLOT:     cfg_q.read_slot     <= cfg_data[9:0];
				owtr_pkg::REG_CONV_WAIT:     cfg_q.conv_wait     <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/owtr_seq.sv */
// bus sequencer: state registers and the per-tick step logic
module owtr_seq #(
	parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  owtr_pkg::tick_t tick,
	input  owtr_pkg::cfg_t  cfg,
	output owtr_pkg::res_t  res
);

	localparam int WW = (TIMER_BITS > 20) ? TIMER_BITS : 20;
	localparam logic [TIMER_BITS-1:0] LIM = {TIMER_BITS{1'b1}} - TIMER_BITS'(2);

	owtr_pkg::phase_t      phase_q, phase_b, phase_n;
	logic [TIMER_BITS-1:0] tick_q, tick_b, tick_n, tc;
	logic [2:0]            bit_q, bit_b, bit_n;
	logic [7:0]            shift_q, shift_b, shift_n;
	logic [3:0]            step_q, step_b, step_n;
	logic [1:0]            op_q, op_b;
	logic [15:0]           result_q, result_n;
	logic                  pres_q, pres_b, pres_n;
	logic                  drive, busy, fin, conv_zero, starting;
	logic [TIMER_BITS-1:0] len_rlow, len_rdly, len_pres, len_rrec, len_ws, len_rs, len_conv;
	owtr_pkg::begin_t      bs_start, bs_end;

	// phase length: zero acts as one unless allowed, saturated to the timer range
	function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [WW-1:0] v,
		input logic zero_ok);
		logic [WW-1:0] x;
		x = v;
		if (x == '0 && !zero_ok)
			x = WW'(1);
		if (x > WW'(LIM))
			x = WW'(LIM);
		return x[TIMER_BITS-1:0];
	endfunction

	always_comb begin
		len_rlow  = clamp_len(WW'(cfg.reset_low), 1'b0);
		len_rdly  = clamp_len(WW'(cfg.pres_delay), 1'b0);
		len_pres  = clamp_len(WW'(cfg.pres_timeout), 1'b0);
		len_rrec  = clamp_len(WW'(cfg.reset_recover), 1'b0);
		len_ws    = clamp_len(WW'(cfg.write_slot), 1'b0);
		len_rs    = clamp_len(WW'(cfg.read_slot), 1'b0);
		len_conv  = clamp_len(WW'(cfg.conv_wait), 1'b1);
		conv_zero = (len_conv == '0);
	end

	always_comb begin
		starting = (phase_q == owtr_pkg::PH_IDLE) && tick.start_req;
		bs_start = owtr_pkg::begin_step(tick.operation, 4'd0, tick.write_byte, conv_zero);

		// state after a possible start
		phase_b = phase_q;
		tick_b  = tick_q;
		bit_b   = bit_q;
		shift_b = shift_q;
		step_b  = step_q;
		op_b    = op_q;
		pres_b  = pres_q;
		if (starting) begin
			phase_b = bs_start.phase;
			tick_b  = '0;
			bit_b   = 3'd0;
			shift_b = bs_start.shift;
			step_b  = bs_start.step;
			op_b    = tick.operation;
			pres_b  = 1'b1;
		end

		bs_end = owtr_pkg::begin_step(op_b, step_b + 4'd1, 8'h00, conv_zero);

		tc       = tick_b + TIMER_BITS'(1);
		phase_n  = phase_b;
		tick_n   = tick_b;
		bit_n    = bit_b;
		shift_n  = shift_b;
		step_n   = step_b;
		pres_n   = pres_b;
		result_n = result_q;
		drive    = 1'b0;
		busy     = 1'b0;
		fin      = 1'b0;

		if (phase_b != owtr_pkg::PH_IDLE) begin
			busy   = 1'b1;
			tick_n = tc;
			case (phase_b)
				owtr_pkg::PH_RLOW: begin
					drive = 1'b1;
					if (tc >= len_rlow) begin
						phase_n = owtr_pkg::PH_RDLY;
						tick_n  = '0;
					end
				end
				owtr_pkg::PH_RDLY: begin
					if (tc >= len_rdly) begin
						phase_n = owtr_pkg::PH_PRES;
						tick_n  = '0;
					end
				end
				owtr_pkg::PH_PRES: begin
					if (!tick.line_level) begin
						phase_n = owtr_pkg::PH_RREC;
						tick_n  = '0;
					end else if (tc >= len_pres) begin
						pres_n  = 1'b0;
						phase_n = bs_end.phase;
						shift_n = bs_end.shift;
						step_n  = bs_end.step;
						tick_n  = '0;
						bit_n   = 3'd0;
						fin     = bs_end.fin;
					end
				end
				owtr_pkg::PH_RREC: begin
					if (tc >= len_rrec) begin
						phase_n = bs_end.phase;
						shift_n = bs_end.shift;
						step_n  = bs_end.step;
						tick_n  = '0;
						bit_n   = 3'd0;
						fin     = bs_end.fin;
					end
				end
				owtr_pkg::PH_WBIT: begin
					if (tc == TIMER_BITS'(1))
						drive = 1'b1;
					else if (tc <= len_ws + TIMER_BITS'(1))
						drive = !shift_b[bit_b];
					if (tc >= len_ws + TIMER_BITS'(2)) begin
						tick_n = '0;
						if (bit_b == 3'd7) begin
							phase_n = bs_end.phase;
							shift_n = bs_end.shift;
							step_n  = bs_end.step;
							bit_n   = 3'd0;
							fin     = bs_end.fin;
						end else begin
							bit_n = bit_b + 3'd1;
						end
					end
				end
				owtr_pkg::PH_RBIT: begin
					if (tc == TIMER_BITS'(1))
						drive = 1'b1;
					else if (tc == TIMER_BITS'(2) && tick.line_level)
						shift_n[bit_b] = 1'b1;
					if (tc >= len_rs + TIMER_BITS'(2)) begin
						tick_n = '0;
						if (bit_b == 3'd7) begin
							// high byte of the temperature lands above the low byte
							if (op_b == owtr_pkg::OP_TEMP && step_b == owtr_pkg::STEP_HIGH_BYTE)
								result_n = {shift_n, result_q[7:0]};
							else
								result_n = {8'h00, shift_n};
							phase_n = bs_end.phase;
							shift_n = bs_end.shift;
							step_n  = bs_end.step;
							bit_n   = 3'd0;
							fin     = bs_end.fin;
						end else begin
							bit_n = bit_b + 3'd1;
						end
					end
				end
				owtr_pkg::PH_CONV: begin
					if (tc >= len_conv) begin
						phase_n = bs_end.phase;
						shift_n = bs_end.shift;
						step_n  = bs_end.step;
						tick_n  = '0;
						bit_n   = 3'd0;
						fin     = bs_end.fin;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
			if (fin) begin
				phase_n = owtr_pkg::PH_IDLE;
				tick_n  = '0;
			end
		end

		res.drive_low   = drive;
		res.busy_res    = busy;
		res.done_res    = fin;
		res.presence_ok = pres_n;
		res.read_value  = result_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= owtr_pkg::PH_IDLE;
			tick_q   <= '0;
			bit_q    <= 3'd0;
			shift_q  <= 8'h00;
			step_q   <= 4'd0;
			op_q     <= owtr_pkg::OP_RESET;
			result_q <= 16'h0000;
			pres_q   <= 1'b1;
		end else if (step_en) begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			shift_q  <= shift_n;
			step_q   <= step_n;
			op_q     <= op_b;
			result_q <= result_n;
			pres_q   <= pres_n;
		end
	end

endmodule

/* src/one_wire_master_temp_read.sv */
// top level of the tick-driven single-wire bus master with temperature read
// Usage: every input transfer is one timer tick carrying start_req, operation,
// write_byte and the sampled line_level. Every tick yields exactly one result
// transfer with drive_low (open-drain low enable), busy_res, done_res,
// presence_ok and read_value. A start on an idle tick begins the operation
// in that same tick; starts while busy are ignored.
// A tick is taken into the input register, stepped through the sequencer and
// captured in the result register, from which it is offered. The block takes
// one tick per clock while the receiver keeps taking results.
// The configuration port writes the slot lengths; write only
// while no tick is in flight.
// Reset clears the sequencer to idle (presence flag one, read result zero) and
// the timing registers to their defaults, but not the result register.
// When the receiver stalls, the result register holds, the input register
// keeps its tick, and in_ready drops once both are full.
module one_wire_master_temp_read #(
	parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             start_req,
	input  logic [1:0]                       operation,
	input  logic [7:0]                       write_byte,
	input  logic                             line_level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             drive_low,
	output logic                             busy_res,
	output logic                             done_res,
	output logic                             presence_ok,
	output logic [15:0]                      read_value,
	input  logic                             cfg_we,
	input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	owtr_pkg::cfg_t  cfg;
	owtr_pkg::tick_t tick_s1;
	owtr_pkg::res_t  res, res_q;
	logic            valid_s1, out_valid_q, advance;

	// tick moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	owtr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owtr_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.tick    (tick_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.start_req  <= start_req;
			tick_s1.operation  <= operation;
			tick_s1.write_byte <= write_byte;
			tick_s1.line_level <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign drive_low   = res_q.drive_low;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign presence_ok = res_q.presence_ok;
	assign read_value  = res_q.read_value;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while result register empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full and stalled");

	a_transfer_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted tick lost before the sequencer");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (done_res || drive_low)) |-> busy_res)
		else $error("done or drive low outside an operation");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stepped tick produced no result");

endmodule

/* tb/sv/tb_top.sv */
// testbench for the single-wire bus master: tick stimulus, live prediction and result checking
`timescale 1ns / 1ps

module tb_top;
	import owtr_pkg::*;

	localparam logic [7:0] SKIP_ROM_BYTE = 8'hCC;
	localparam logic [7:0] CONVERT_BYTE  = 8'h44;
	localparam logic [7:0] READ_PAD_BYTE = 8'hBE;
	localparam int         SETTLE_CYCLES = 8;

	localparam item_code_t TEMP_ORDER [0:9] = '{
		IT_RESET, IT_WCC, IT_W44, IT_CONV, IT_RESET, IT_WCC, IT_WBE, IT_READ, IT_READ, IT_END
	};

	class bus_master_scoreboard;
		cfg_t        cfg;
		phase_t      ph;
		int unsigned ticks;
		int          bit_idx;
		logic [7:0]  shifter;
		logic [3:0]  step;
		logic [1:0]  op;
		logic [15:0] word;
		bit          pres;
		res_t        results_due [$];
		int          errors;
		int          checked;

		function new();
			cfg.reset_low     = 12'd500;
			cfg.pres_delay    = 10'd30;
			cfg.pres_timeout  = 10'd254;
			cfg.reset_recover = 10'd120;
			cfg.write_slot    = 10'd40;
			cfg.read_slot     = 10'd80;
			cfg.conv_wait     = 20'd0;
			ph      = PH_IDLE;
			ticks   = 0;
			bit_idx = 0;
			shifter = 8'h00;
			step    = 4'd0;
			op      = OP_RESET;
			word    = 16'h0000;
			pres    = 1'b1;
			errors  = 0;
			checked = 0;
		endfunction

		task report(input string what);
			if (errors < 100)
				$display("[%0t] mismatch at result %0d: %s", $realtime, checked, what);
			errors++;
		endtask

		function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_RESET_LOW:     cfg.reset_low     = v[11:0];
				REG_PRES_DELAY:    cfg.pres_delay    = v[9:0];
				REG_PRES_TIMEOUT:  cfg.pres_timeout  = v[9:0];
				REG_RESET_RECOVER: cfg.reset_recover = v[9:0];
				REG_WRITE_SLOT:    cfg.write_slot    = v[9:0];
				REG_READ_SLOT:     cfg.read_slot     = v[9:0];
				REG_CONV_WAIT:     cfg.conv_wait     = v[19:0];
				default: ;
			endcase
		endfunction

		function bit idle();
			return ph == PH_IDLE;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// a zero length acts as one unless zero is allowed; all lengths saturate
		function longint unsigned span(input logic [19:0] v, input bit zero_ok);
			longint unsigned x;
			longint unsigned lim;
			lim = (64'd1 << TIMER_BITS_DEF) - 64'd3;
			x = v;
			if (x == 0 && !zero_ok) x = 1;
			if (x > lim) x = lim;
			return x;
		endfunction

		function item_code_t item_at(input logic [1:0] o, input logic [3:0] s);
			if (o == OP_TEMP) return (s < 4'd10) ? TEMP_ORDER[s] : IT_END;
			if (s != 4'd0) return IT_END;
			case (o)
				OP_RESET: return IT_RESET;
				OP_WRITE: return IT_WUSER;
				default:  return IT_READ;
			endcase
		endfunction

		// enter the current step, skipping an empty conversion wait; 1 when the op is over
		function bit launch_step(input logic [7:0] user);
			item_code_t it;
			bit         fin;
			bit         settled;
			fin = 1'b0;
			settled = 1'b0;
			while (!settled) begin
				it = item_at(op, step);
				ticks = 0;
				bit_idx = 0;
				settled = 1'b1;
				case (it)
					IT_RESET: ph = PH_RLOW;
					IT_WCC: begin
						ph = PH_WBIT;
						shifter = SKIP_ROM_BYTE;
					end
					IT_W44: begin
						ph = PH_WBIT;
						shifter = CONVERT_BYTE;
					end
					IT_WBE: begin
						ph = PH_WBIT;
						shifter = READ_PAD_BYTE;
					end
					IT_WUSER: begin
						ph = PH_WBIT;
						shifter = user;
					end
					IT_READ: begin
						ph = PH_RBIT;
						shifter = 8'h00;
					end
					IT_CONV: begin
						if (span(cfg.conv_wait, 1'b1) != 0) ph = PH_CONV;
						else begin
							step = step + 4'd1;
							settled = 1'b0;
						end
					end
					default: begin
						ph = PH_IDLE;
						fin = 1'b1;
					end
				endcase
			end
			return fin;
		endfunction

		function bit next_step();
			step = step + 4'd1;
			return launch_step(8'h00);
		endfunction

		function void note_tick(input tick_t t);
			res_t            r;
			longint unsigned tc;
			longint unsigned ws;
			longint unsigned rs;
			bit              fin;
			bit              b;
			r = '0;
			fin = 1'b0;
			if (ph == PH_IDLE && t.start_req) begin
				op = t.operation;
				step = 4'd0;
				pres = 1'b1;
				void'(launch_step(t.write_byte));
			end
			if (ph != PH_IDLE) begin
				r.busy_res = 1'b1;
				ticks++;
				tc = ticks;
				case (ph)
					PH_RLOW: begin
						r.drive_low = 1'b1;
						if (tc >= span(cfg.reset_low, 1'b0)) begin
							ph = PH_RDLY;
							ticks = 0;
						end
					end
					PH_RDLY: begin
						if (tc >= span(cfg.pres_delay, 1'b0)) begin
							ph = PH_PRES;
							ticks = 0;
						end
					end
					PH_PRES: begin
						if (!t.line_level) begin
							ph = PH_RREC;
							ticks = 0;
						end else if (tc >= span(cfg.pres_timeout, 1'b0)) begin
							pres = 1'b0;
							fin = next_step();
						end
					end
					PH_RREC: begin
						if (tc >= span(cfg.reset_recover, 1'b0)) fin = next_step();
					end
					PH_WBIT: begin
						ws = span(cfg.write_slot, 1'b0);
						b = shifter[bit_idx];
						if (tc == 1) r.drive_low = 1'b1;
						else if (tc <= ws + 1) r.drive_low = !b;
						if (tc >= ws + 2) begin
							ticks = 0;
							if (bit_idx >= 7) fin = next_step();
							else bit_idx++;
						end
					end
					PH_RBIT: begin
						rs = span(cfg.read_slot, 1'b0);
						if (tc == 1) r.drive_low = 1'b1;
						else if (tc == 2 && t.line_level) shifter[bit_idx] = 1'b1;
						if (tc >= rs + 2) begin
							ticks = 0;
							if (bit_idx >= 7) begin
								// second read of the temperature sequence is the high byte
								if (op == OP_TEMP && step == 4'd8) word = {shifter, word[7:0]};
								else word = {8'h00, shifter};
								fin = next_step();
							end else begin
								bit_idx++;
							end
						end
					end
					PH_CONV: begin
						if (tc >= span(cfg.conv_wait, 1'b1)) fin = next_step();
					end
					default: begin
						ph = PH_IDLE;
						ticks = 0;
						fin = 1'b1;
					end
				endcase
				if (fin) begin
					r.done_res = 1'b1;
					ph = PH_IDLE;
					ticks = 0;
				end
			end
			r.presence_ok = pres;
			r.read_value = word;
			results_due.push_back(r);
		endfunction

		task check_result(input res_t got);
			res_t want;
			if (results_due.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				want = results_due.pop_front();
				if (got.drive_low !== want.drive_low)
					report($sformatf("drive_low %0b, expected %0b", got.drive_low, want.drive_low));
				if (got.busy_res !== want.busy_res)
					report($sformatf("busy_res %0b, expected %0b", got.busy_res, want.busy_res));
				if (got.done_res !== want.done_res)
					report($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
				if (got.presence_ok !== want.presence_ok)
					report($sformatf("presence_ok %0b, expected %0b",
						got.presence_ok, want.presence_ok));
				if (got.read_value !== want.read_value)
					report($sformatf("read_value %h, expected %h",
						got.read_value, want.read_value));
			end
			checked++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   start_req = 1'b0;
	logic [1:0]             operation = OP_RESET;
	logic [7:0]             write_byte = 8'h00;
	logic                   line_level = 1'b1;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   drive_low;
	logic                   busy_res;
	logic                   done_res;
	logic                   presence_ok;
	logic [15:0]            read_value;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_RESET_LOW;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	bus_master_scoreboard   sb;
	logic [CFG_DATA_W-1:0]  reg_plan [0:6];
	int                     send_gap_pct = 0;
	int                     stall_pct = 0;
	int                     hold_cycles = 0;
	int                     line_force = -1;
	bit                     present = 1'b1;

	one_wire_master_temp_read uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_req   (start_req),
		.operation   (operation),
		.write_byte  (write_byte),
		.line_level  (line_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_low   (drive_low),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.presence_ok (presence_ok),
		.read_value  (read_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check each transfer, then pick the next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(res_t'({drive_low, busy_res, done_res, presence_ok, read_value}));
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// simulated bus: a present device pulls the line low on a random tick of a presence wait
	function automatic tick_t make_tick(input bit want_start, input logic [1:0] op,
		input logic [7:0] wb);
		tick_t t;
		t.start_req = want_start;
		t.operation = op;
		t.write_byte = wb;
		if (sb.ph == PH_PRES) t.line_level = present ? ($urandom_range(3) != 0) : 1'b1;
		else if (line_force < 0) t.line_level = $urandom_range(1);
		else t.line_level = line_force[0];
		return t;
	endfunction

	function automatic tick_t busy_tick();
		return make_tick($urandom_range(9) == 0, 2'($urandom_range(3)), 8'($urandom_range(255)));
	endfunction

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= t.start_req;
		operation <= t.operation;
		write_byte <= t.write_byte;
		line_level <= t.line_level;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(t);
	endtask

	// one full operation, with ignored starts sprinkled over its busy ticks
	task automatic do_op(input logic [1:0] op, input logic [7:0] wb);
		send_tick(make_tick(1'b1, op, wb));
		while (!sb.idle()) send_tick(busy_tick());
	endtask

	task automatic run_random(input int n);
		for (int k = 0; k < n; k++) begin
			if (sb.idle()) begin
				present = ($urandom_range(3) != 0);
				send_tick(make_tick($urandom_range(9) < 8, 2'($urandom_range(3)),
					8'($urandom_range(255))));
			end else begin
				send_tick(busy_tick());
			end
		end
	endtask

	// finish the running operation and drain all results before touching registers
	task automatic settle();
		while (!sb.idle()) send_tick(make_tick(1'b0, OP_RESET, 8'h00));
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs();
		for (int i = REG_RESET_LOW; i <= REG_CONV_WAIT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= reg_plan[i];
			@(posedge clk);
			sb.set_reg(CFG_INDEX_W'(i), reg_plan[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic plan_all(input int low, input int slot, input int conv);
		reg_plan[REG_RESET_LOW]     = CFG_DATA_W'(low);
		reg_plan[REG_PRES_DELAY]    = CFG_DATA_W'(slot);
		reg_plan[REG_PRES_TIMEOUT]  = CFG_DATA_W'(slot);
		reg_plan[REG_RESET_RECOVER] = CFG_DATA_W'(slot);
		reg_plan[REG_WRITE_SLOT]    = CFG_DATA_W'(slot);
		reg_plan[REG_READ_SLOT]     = CFG_DATA_W'(slot);
		reg_plan[REG_CONV_WAIT]     = CFG_DATA_W'(conv);
	endtask

	// short timings keep operations brief; bits above a register's width are junk
	task automatic plan_random();
		reg_plan[REG_RESET_LOW]     = CFG_DATA_W'($urandom_range(6) | ($urandom_range(255) << 12));
		reg_plan[REG_PRES_DELAY]    = CFG_DATA_W'($urandom_range(4) | ($urandom_range(1023) << 10));
		reg_plan[REG_PRES_TIMEOUT]  = CFG_DATA_W'($urandom_range(8) | ($urandom_range(1023) << 10));
		reg_plan[REG_RESET_RECOVER] = CFG_DATA_W'($urandom_range(4) | ($urandom_range(1023) << 10));
		reg_plan[REG_WRITE_SLOT]    = CFG_DATA_W'($urandom_range(3) | ($urandom_range(1023) << 10));
		reg_plan[REG_READ_SLOT]     = CFG_DATA_W'($urandom_range(3) | ($urandom_range(1023) << 10));
		reg_plan[REG_CONV_WAIT]     = CFG_DATA_W'($urandom_range(1) ? $urandom_range(10) : 0);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on timings
		present = 1'b1;
		do_op(OP_WRITE, 8'hA5);

		// zero lengths act as one, zero conversion wait is skipped
		settle();
		plan_all(0, 0, 0);
		load_regs();
		do_op(OP_TEMP, 8'h00);
		present = 1'b0;
		do_op(OP_RESET, 8'h00);
		present = 1'b1;
		do_op(OP_WRITE, 8'h5A);
		line_force = 1;
		do_op(OP_READ, 8'h00);
		line_force = 0;
		do_op(OP_READ, 8'hFF);
		line_force = -1;

		settle();
		plan_all(1, 1, 1);
		load_regs();
		do_op(OP_TEMP, 8'h00);
		present = 1'b0;
		do_op(OP_TEMP, 8'h3C);

		for (int m = 0; m < 4; m++) begin
			case (m)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 54; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 54; end
				default: begin send_gap_pct = 9; stall_pct = 9; end
			endcase
			for (int p = 0; p < 2; p++) begin
				settle();
				plan_random();
				load_regs();
				if (m == 0 && p == 1) begin
					// result side stops for a long stretch while ticks keep coming
					hold_cycles = 300;
					run_random(60);
				end
				run_random(120);
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
